// ===== sv/round_robin_ready_queue_unit_defines.svh =====
// Assertion macros for the ready queue RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ROUND_ROBIN_READY_QUEUE_UNIT_DEFINES_SVH
`define ROUND_ROBIN_READY_QUEUE_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define RRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define RRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rrq_pkg.sv =====
// Shared types and constants for the round-robin ready queue.
// No dependencies.
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 8;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEXT   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NULL      = 3'd4
  } status_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             fire;
    op_e              op;
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  front;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

// ===== sv/round_robin_ready_queue_unit.sv =====
// Round-robin ready queue: a chain of slot cells with the front at position 0.
// The result is registered and appears in the cycle after the input transaction is accepted.
// One transaction per cycle while the result is drained or free; admit, remove and rotate
// each complete through the match chain across the cells and their single-step shift.
// Reset clears the fill level and the result valid; slot contents are undefined
// until written and are never read beyond the fill level.
`timescale 1ns / 1ps
`include "round_robin_ready_queue_unit_defines.svh"

module round_robin_ready_queue_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rrq_pkg::OP_W-1:0]       op_i,
  input  logic [rrq_pkg::ID_W-1:0]       thread_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rrq_pkg::ID_W-1:0]       next_thread_o,
  output logic [rrq_pkg::CNT_W-1:0]      queue_length_o,
  output logic [rrq_pkg::STATUS_W-1:0]   status_o
);
  import rrq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic [ID_W-1:0]  next_thread_q, next_thread_d;
  logic [CNT_W-1:0] queue_length_q;
  status_e          status_q, status_d;

  logic             fire;
  op_e              op;
  logic             id_nz;
  cell_cmd_t        cmd;
  logic [ID_W-1:0]  slot   [QUEUE_DEPTH];
  logic             found  [QUEUE_DEPTH+1];

  // A new transaction is taken whenever the result register is free or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign op         = op_e'(op_i);
  assign id_nz      = thread_id_i != '0;

  // Command broadcast to the cell chain.
  assign cmd.fire  = fire;
  assign cmd.op    = op;
  assign cmd.id    = thread_id_i;
  assign cmd.front = slot[0];
  assign cmd.count = count_q;

  // Chain of slot cells; the search flag ripples from the front to the back.
  assign found[0] = 1'b0;
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ID_W-1:0] right;
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right = slot[g];
    end else begin : g_body
      assign right = slot[g+1];
    end
    rrq_cell u_cell (
      .clk_i   (clk_i),
      .pos_i   (CNT_W'(g)),
      .cmd_i   (cmd),
      .right_i (right),
      .found_i (found[g]),
      .slot_o  (slot[g]),
      .found_o (found[g+1])
    );
  end

  // Result and new fill level for the operation.
  always_comb begin
    count_d       = count_q;
    next_thread_d = '0;
    status_d      = ST_OK;
    case (op)
      OP_ADMIT: begin
        if (!id_nz) begin
          status_d = ST_NULL;
        end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!id_nz) begin
          status_d = ST_NULL;
        end else if (!found[QUEUE_DEPTH]) begin
          status_d = ST_NOT_FOUND;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_NEXT: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          next_thread_d = slot[0];
        end
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  // Control state: fill level and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      next_thread_q  <= next_thread_d;
      queue_length_q <= count_d;
      status_q       <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_thread_o  = next_thread_q;
  assign queue_length_o = queue_length_q;
  assign status_o       = status_q;

  // Checks on the queue bookkeeping.
  `RRQ_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "fill level beyond depth")
  `RRQ_ASSERT(a_len_tracks, out_valid_q |-> (queue_length_q == count_q), "length out of step")
  `RRQ_ASSERT(a_empty_result, (out_valid_q && status_q == ST_EMPTY) |-> (next_thread_q == '0 && queue_length_q == '0), "bad empty result")
  `RRQ_ASSERT_NXT(a_admit_grows, fire && op == OP_ADMIT && id_nz && count_q != CNT_W'(QUEUE_DEPTH), count_q == $past(count_q) + CNT_W'(1), "admit did not grow queue")
  `RRQ_ASSERT_NXT(a_clear_empties, fire && op == OP_CLEAR, count_q == '0, "clear left entries")

endmodule

// ===== sv/rrq_cell.sv =====
// One slot of the ready queue chain: holds an identifier and shifts or loads it.
// Depends on rrq_pkg.
`timescale 1ns / 1ps

module rrq_cell (
  input  logic                          clk_i,
  input  logic [rrq_pkg::CNT_W-1:0]     pos_i,
  input  rrq_pkg::cell_cmd_t            cmd_i,
  input  logic [rrq_pkg::ID_W-1:0]      right_i,
  input  logic                          found_i,
  output logic [rrq_pkg::ID_W-1:0]      slot_o,
  output logic                          found_o
);
  import rrq_pkg::*;

  logic [ID_W-1:0]  slot_q, slot_d;
  logic [CNT_W-1:0] pos_next;
  logic             occupied;
  logic             match;
  logic             before_last;
  logic             is_last;
  logic             id_nz;

  // Position tests against the current fill level.
  assign pos_next    = pos_i + CNT_W'(1);
  assign occupied    = pos_i < cmd_i.count;
  assign before_last = pos_next < cmd_i.count;
  assign is_last     = pos_next == cmd_i.count;
  assign id_nz       = cmd_i.id != '0;

  // A match here or in any cell closer to the front marks the gap to close.
  assign match   = occupied && (slot_q == cmd_i.id);
  assign found_o = found_i | match;
  assign slot_o  = slot_q;

  // Choose between hold, shift from the right neighbor and a load.
  always_comb begin
    slot_d = slot_q;
    if (cmd_i.fire) begin
      case (cmd_i.op)
        OP_ADMIT: begin
          if (id_nz && (pos_i == cmd_i.count)) slot_d = cmd_i.id;
        end
        OP_REMOVE: begin
          if (id_nz && found_o && before_last) slot_d = right_i;
        end
        OP_NEXT: begin
          if (before_last) begin
            slot_d = right_i;
          end else if (is_last) begin
            slot_d = cmd_i.front;
          end
        end
        default: begin
          slot_d = slot_q;
        end
      endcase
    end
  end

  // Slot contents carry no reset; the fill level qualifies them.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule
